>>> sv/adln_pkg.sv
// shared types, constants and microcode for the adaline lms trainer
package adln_pkg;

   // fixed-point format and field widths
   localparam int FRAC_BITS = 12;
   localparam int MODE_W    = 2;
   localparam int SAMPLE_W  = 16;
   localparam int WGT_W     = 32;
   localparam int SQ_W      = 48;
   localparam int RATE_W    = 16;
   localparam int LIMIT_W   = 48;
   localparam int ERR_W     = WGT_W + 1;
   localparam int OPA_W     = ERR_W;
   localparam int OPB_W     = 25;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int ACC_W     = ((PROD_W > WGT_W + FRAC_BITS) ? PROD_W : WGT_W + FRAC_BITS) + 2;
   localparam int SQ_FIT_W  = 24;

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_IDX_LO = 3;

   localparam logic [CSR_IDX_W-1:0] REG_RATE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INIT  = 2'd2;

   // reset values: learning rate 0.01, error limit and initial weight 0.1, in the respective formats
   localparam logic [RATE_W-1:0]        RATE_RST  = 16'd655;
   localparam logic [LIMIT_W-1:0]       LIMIT_RST =
      LIMIT_W'(((64'd1 << (2 * FRAC_BITS)) + 64'd5) / 64'd10);
   localparam logic signed [WGT_W-1:0]  INIT_RST  =
      WGT_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

   // item modes
   localparam logic [MODE_W-1:0] MODE_TRAIN   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INFER   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0]          mode;
      logic signed [SAMPLE_W-1:0] sample_one;
      logic signed [SAMPLE_W-1:0] sample_two;
      logic signed [SAMPLE_W-1:0] target;
      logic                       epoch_last;
   } req_type;

   typedef struct packed {
      logic signed [WGT_W-1:0] net_value;
      logic [SQ_W-1:0]         squared_error;
      logic                    class_out;
      logic                    epoch_done;
      logic                    converged;
      logic signed [WGT_W-1:0] weight_one_out;
      logic signed [WGT_W-1:0] weight_two_out;
      logic signed [WGT_W-1:0] bias_out;
   } rsp_type;

   // microcode
   typedef enum logic [2:0] {
      MUL_IDLE,
      MUL_W1X1,
      MUL_W2X2,
      MUL_RATE_ERR,
      MUL_ERR_SQ,
      MUL_STEP_X1,
      MUL_STEP_X2
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_ALWAYS,
      JMP_NOT_TRAIN
   } jump_type;

   localparam int UCODE_DEPTH = 11;
   localparam int PC_W        = $clog2(UCODE_DEPTH);

   localparam logic [PC_W-1:0] UC_START   = PC_W'(0);
   localparam logic [PC_W-1:0] UC_RESTART = PC_W'(9);
   localparam logic [PC_W-1:0] UC_FINISH  = PC_W'(10);

   typedef struct packed {
      mul_sel_type     mul_sel;
      acc_op_type      acc_op;
      logic            net_en;
      logic            err_en;
      logic            step_en;
      logic            sq_en;
      logic            w1_en;
      logic            sum_en;
      logic            w2b_en;
      logic            epoch_en;
      logic            restart_en;
      logic            emit;
      jump_type        jump;
      logic [PC_W-1:0] target;
   } ctrl_type;

   localparam ctrl_type CTRL_NOP = ctrl_type'('0);

   function automatic ctrl_type ucode(input logic [PC_W-1:0] pc);
      ctrl_type c;
      c = CTRL_NOP;
      case (pc)
         PC_W'(0): begin
            c.mul_sel = MUL_W1X1;
            c.acc_op  = ACC_LOAD;
         end
         PC_W'(1): begin
            c.mul_sel = MUL_W2X2;
            c.acc_op  = ACC_ADD;
         end
         PC_W'(2): begin
            c.net_en = 1'b1;
            c.jump   = JMP_NOT_TRAIN;
            c.target = UC_FINISH;
         end
         PC_W'(3): begin
            c.err_en = 1'b1;
         end
         PC_W'(4): begin
            c.mul_sel = MUL_RATE_ERR;
         end
         PC_W'(5): begin
            c.mul_sel = MUL_ERR_SQ;
            c.step_en = 1'b1;
         end
         PC_W'(6): begin
            c.mul_sel = MUL_STEP_X1;
            c.sq_en   = 1'b1;
         end
         PC_W'(7): begin
            c.mul_sel = MUL_STEP_X2;
            c.w1_en   = 1'b1;
            c.sum_en  = 1'b1;
         end
         PC_W'(8): begin
            c.w2b_en   = 1'b1;
            c.epoch_en = 1'b1;
            c.jump     = JMP_ALWAYS;
            c.target   = UC_FINISH;
         end
         PC_W'(9): begin
            c.restart_en = 1'b1;
         end
         PC_W'(10): begin
            c.emit = 1'b1;
         end
         default: begin
            // unused addresses fall back to the result step
            c.jump   = JMP_ALWAYS;
            c.target = UC_FINISH;
         end
      endcase
      return c;
   endfunction

   localparam logic signed [ACC_W-1:0] WORD_MAX = ACC_W'(64'sd2147483647);
   localparam logic signed [ACC_W-1:0] WORD_MIN = -WORD_MAX - ACC_W'(64'sd1);

   // clamp a wide signed value to the 32 bit weight range
   function automatic logic signed [WGT_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
      logic signed [WGT_W-1:0] r;
      if (v > WORD_MAX) begin
         r = WGT_W'(WORD_MAX);
      end else if (v < WORD_MIN) begin
         r = WGT_W'(WORD_MIN);
      end else begin
         r = WGT_W'(v);
      end
      return r;
   endfunction

endpackage

>>> sv/adln_datapath.sv
// arithmetic datapath: shared multiplier, accumulator, weights and epoch sum
module adln_datapath import adln_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  req_type                    start_item,
   input  ctrl_type                   ctrl,
   input  logic [RATE_W-1:0]          learning_rate,
   input  logic [LIMIT_W-1:0]         error_limit,
   input  logic signed [WGT_W-1:0]    initial_weight,
   output logic                       is_train,
   output rsp_type                    result
);

   req_type                    item_ff, item_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [WGT_W-1:0]    net_ff, net_in;
   logic                       class_ff, class_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [ERR_W-1:0]    step_ff, step_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic                       done_ff, done_in;
   logic                       conv_ff, conv_in;
   logic signed [WGT_W-1:0]    w1_ff, w1_in;
   logic signed [WGT_W-1:0]    w2_ff, w2_in;
   logic signed [WGT_W-1:0]    bias_ff, bias_in;
   logic [SQ_W-1:0]            sum_ff, sum_in;

   logic signed [OPA_W-1:0]    opa;
   logic signed [OPB_W-1:0]    opb;
   logic signed [OPB_W-1:0]    err_lo;
   logic signed [ACC_W-1:0]    net_sum;
   logic signed [ACC_W-1:0]    upd_w;
   logic signed [ACC_W-1:0]    upd_b;
   logic [SQ_W:0]              sum_add;
   logic                       sq_fits;

   assign is_train = (item_ff.mode == MODE_TRAIN);

   // operand select for the shared multiplier
   always_comb begin
      err_lo = err_ff[OPB_W-1:0];
      opa    = '0;
      opb    = '0;
      case (ctrl.mul_sel)
         MUL_W1X1: begin
            opa = OPA_W'(w1_ff);
            opb = OPB_W'(item_ff.sample_one);
         end
         MUL_W2X2: begin
            opa = OPA_W'(w2_ff);
            opb = OPB_W'(item_ff.sample_two);
         end
         MUL_RATE_ERR: begin
            opa = err_ff;
            opb = OPB_W'($signed({1'b0, learning_rate}));
         end
         MUL_ERR_SQ: begin
            opa = OPA_W'(err_lo);
            opb = err_lo;
         end
         MUL_STEP_X1: begin
            opa = step_ff;
            opb = OPB_W'(item_ff.sample_one);
         end
         MUL_STEP_X2: begin
            opa = step_ff;
            opb = OPB_W'(item_ff.sample_two);
         end
         default: begin
            opa = '0;
            opb = '0;
         end
      endcase
   end

   always_comb begin
      // the square is exact only while |e| stays below 2^24
      sq_fits = (err_ff[ERR_W-1:SQ_FIT_W] == '0) ||
                ((err_ff[ERR_W-1:SQ_FIT_W] == '1) && (err_ff[SQ_FIT_W-1:0] != '0));
      net_sum = acc_ff + ACC_W'(prod_ff);
      upd_w   = (ACC_W'(prod_ff) >>> FRAC_BITS);
      upd_b   = ACC_W'(bias_ff) + ACC_W'(step_ff);
      sum_add = {1'b0, sum_ff} + {1'b0, sq_ff};

      item_in  = item_ff;
      prod_in  = opa * opb;
      acc_in   = acc_ff;
      net_in   = net_ff;
      class_in = class_ff;
      err_in   = err_ff;
      step_in  = step_ff;
      sq_in    = sq_ff;
      done_in  = done_ff;
      conv_in  = conv_ff;
      w1_in    = w1_ff;
      w2_in    = w2_ff;
      bias_in  = bias_ff;
      sum_in   = sum_ff;

      if (start) begin
         item_in  = start_item;
         net_in   = '0;
         class_in = 1'b0;
         sq_in    = '0;
         done_in  = 1'b0;
         conv_in  = 1'b0;
      end

      case (ctrl.acc_op)
         ACC_LOAD: acc_in = ACC_W'(bias_ff) <<< FRAC_BITS;
         ACC_ADD:  acc_in = net_sum;
         default:  acc_in = acc_ff;
      endcase

      if (ctrl.net_en) begin
         net_in   = sat_word(net_sum >>> FRAC_BITS);
         class_in = ~net_in[WGT_W-1];
      end
      if (ctrl.err_en) begin
         err_in = ERR_W'(item_ff.target) - ERR_W'(net_ff);
      end
      if (ctrl.step_en) begin
         step_in = ERR_W'(prod_ff >>> RATE_W);
      end
      if (ctrl.sq_en) begin
         sq_in = sq_fits ? prod_ff[SQ_W-1:0] : '1;
      end
      if (ctrl.w1_en) begin
         w1_in = sat_word(ACC_W'(w1_ff) + upd_w);
      end
      if (ctrl.sum_en) begin
         sum_in = sum_add[SQ_W] ? '1 : sum_add[SQ_W-1:0];
      end
      if (ctrl.w2b_en) begin
         w2_in   = sat_word(ACC_W'(w2_ff) + upd_w);
         bias_in = sat_word(upd_b);
      end
      if (ctrl.epoch_en && item_ff.epoch_last) begin
         done_in = 1'b1;
         conv_in = ((sum_ff >> 1) <= error_limit);
         sum_in  = '0;
      end
      if (ctrl.restart_en) begin
         w1_in   = initial_weight;
         w2_in   = initial_weight;
         bias_in = initial_weight;
         sum_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w1_ff   <= INIT_RST;
         w2_ff   <= INIT_RST;
         bias_ff <= INIT_RST;
         sum_ff  <= '0;
      end else begin
         w1_ff   <= w1_in;
         w2_ff   <= w2_in;
         bias_ff <= bias_in;
         sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      net_ff   <= net_in;
      class_ff <= class_in;
      err_ff   <= err_in;
      step_ff  <= step_in;
      sq_ff    <= sq_in;
      done_ff  <= done_in;
      conv_ff  <= conv_in;
   end

   always_comb begin
      result.net_value      = net_ff;
      result.squared_error  = sq_ff;
      result.class_out      = class_ff;
      result.epoch_done     = done_ff;
      result.converged      = conv_ff;
      result.weight_one_out = w1_ff;
      result.weight_two_out = w2_ff;
      result.bias_out       = bias_ff;
   end

endmodule

>>> sv/adaline_lms_neuron_trainer_unit.sv
// top level: microcode sequencer, register file and result register
//
// Two-input ADALINE neuron with bias, trained by the LMS rule in fixed point.
// Items enter on req_valid/req_ready with a req_type payload; one result per
// item leaves on rsp_valid/rsp_ready with a rsp_type payload. Registers sit
// on the csr_ APB-style port at byte addresses 0, 8 and 16.
// One item is worked at a time by an 11-step microprogram that drives a
// single shared 33x25 multiplier; each multiply and add takes its own step.
// Train items run every step but the restart step; infer items jump from
// the net step to the result step; restart items run only the restart and
// result steps. req_ready returns only at the edge that loads the result.
// The result register frees the datapath: the next item is accepted while
// a result still waits. If that result is still not taken when the next one
// is ready, the sequencer holds at its result step until the transfer.
// Synchronous reset restores the registers to their defaults, all weights
// to 0.1 and the epoch sum to zero; no clearing pass is needed.
module adaline_lms_neuron_trainer_unit import adln_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   logic                     busy_ff, busy_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [RATE_W-1:0]        rate_ff, rate_in;
   logic [LIMIT_W-1:0]       limit_ff, limit_in;
   logic signed [WGT_W-1:0]  init_ff, init_in;

   ctrl_type                 ctrl;
   ctrl_type                 dp_ctrl;
   logic                     accept;
   logic                     out_free;
   logic                     emit_now;
   logic                     is_train;
   logic                     csr_wr;
   logic [CSR_IDX_W-1:0]     csr_idx;
   rsp_type                  dp_result;

   assign ctrl      = ucode(pc_ff);
   assign dp_ctrl   = busy_ff ? ctrl : CTRL_NOP;
   assign req_ready = ~busy_ff;
   assign accept    = req_valid & ~busy_ff;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign emit_now  = busy_ff & ctrl.emit & out_free;

   // step counter and dispatch
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = (req_data.mode == MODE_RESTART) ? UC_RESTART : UC_START;
      end else if (busy_ff) begin
         if (ctrl.emit) begin
            if (out_free) begin
               busy_in = 1'b0;
               pc_in   = UC_START;
            end
         end else if ((ctrl.jump == JMP_ALWAYS) ||
                      ((ctrl.jump == JMP_NOT_TRAIN) && ~is_train)) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit_now) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = dp_result;
      end
   end

   // register file
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[CSR_IDX_LO +: CSR_IDX_W];
   assign csr_pready = 1'b1;

   always_comb begin
      rate_in  = rate_ff;
      limit_in = limit_ff;
      init_in  = init_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_RATE:  rate_in  = csr_pwdata[RATE_W-1:0];
            REG_LIMIT: limit_in = csr_pwdata[LIMIT_W-1:0];
            REG_INIT:  init_in  = csr_pwdata[WGT_W-1:0];
            default:   rate_in  = rate_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_RATE:  csr_prdata = CSR_DATA_W'(rate_ff);
         REG_LIMIT: csr_prdata = CSR_DATA_W'(limit_ff);
         REG_INIT:  csr_prdata = CSR_DATA_W'($unsigned(init_ff));
         default:   csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= UC_START;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= RATE_RST;
         limit_ff     <= LIMIT_RST;
         init_ff      <= INIT_RST;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
         limit_ff     <= limit_in;
         init_ff      <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   adln_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .start          (accept),
      .start_item     (req_data),
      .ctrl           (dp_ctrl),
      .learning_rate  (rate_ff),
      .error_limit    (limit_ff),
      .initial_weight (init_ff),
      .is_train       (is_train),
      .result         (dp_result)
   );

endmodule

>>> sv/adln_checker.sv
// port-level checks for the adaline lms trainer, bound to the top level
module adln_checker import adln_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // one item in work at a time
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after a transfer");

   // no result appears in the cycle after an item enters an empty output
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

   // converged only reported on an epoch close
   a_conv_needs_epoch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.converged |-> rsp_data.epoch_done)
      else $error("converged without epoch end");

   // a negative net never gives the plus class
   a_class_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.net_value[WGT_W-1] |-> !rsp_data.class_out)
      else $error("class disagrees with sign of net");

endmodule

bind adaline_lms_neuron_trainer_unit adln_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
